@@ rtl/core/tics_pkg.sv @@
package tics_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_INTERP = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        STAT_OK    = 3'd0,
        STAT_EMPTY = 3'd1,
        STAT_FULL  = 3'd2,
        STAT_ORDER = 3'd3,
        STAT_NEG   = 3'd4
    } stat_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_BLD_PAD,
        S_BLD_FIRST,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SCAN_ACC,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_RNG_RD,
        S_RNG_LO,
        S_RNG_HI,
        S_RNG_MUL,
        S_RNG_SUM,
        S_BIN_RDA,
        S_BIN_A,
        S_BIN_B,
        S_BIN_SQ,
        S_BIN_GO,
        S_LIN_WAIT,
        S_QMD_WAIT,
        S_SQRT_WAIT,
        S_DIV_WAIT,
        S_FIN_A,
        S_FIN_B,
        S_INT_RDA,
        S_INT_A,
        S_INT_B,
        S_INT_MUL,
        S_INT_GO,
        S_INT_WAIT
    } fsm_t;

    typedef enum logic [1:0] {
        M_EMIN,
        M_EMAX,
        M_CUM,
        M_INT
    } search_mode_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_state_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_RUN,
        SQ_SQR,
        SQ_FIX
    } sq_state_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
        logic        inexact;
    } md_res_t;

    typedef struct packed {
        logic        done;
        logic [32:0] root;
    } sq_res_t;

endpackage

@@ rtl/core/tics_muldiv.sv @@
// floor(a*b/c): 64x64 product from four registered 32x32 partials, then
// restoring division one quotient bit per cycle.
module tics_muldiv
    import tics_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    input  logic [63:0] c,
    output md_res_t     res
);

    md_state_t    state_reg, state_next;
    logic [63:0]  a_reg, a_next;
    logic [63:0]  b_reg, b_next;
    logic [63:0]  c_reg, c_next;
    logic [127:0] prod_reg, prod_next;
    logic [63:0]  pp_reg, pp_next;
    logic [6:0]   step_reg, step_next;
    logic [63:0]  rem_reg, rem_next;
    logic [63:0]  quo_reg, quo_next;
    logic         done_reg, done_next;

    logic [1:0]   acc_idx;
    logic [6:0]   sh_amt;
    logic [127:0] pp_sh;
    logic [64:0]  rem2;
    logic [64:0]  diff;

    assign acc_idx = step_reg[1:0] - 2'd1;
    assign pp_sh   = {64'd0, pp_reg} << sh_amt;
    assign rem2    = {rem_reg, prod_reg[127]};
    assign diff    = rem2 - {1'b0, c_reg};

    always_comb
    begin
        case (acc_idx)
            2'd0:    sh_amt = 7'd0;
            2'd1:    sh_amt = 7'd32;
            2'd2:    sh_amt = 7'd32;
            default: sh_amt = 7'd64;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        prod_reg <= prod_next;
        pp_reg   <= pp_next;
        step_reg <= step_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
    end

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        prod_next  = prod_reg;
        pp_next    = pp_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        done_next  = 1'b0;
        case (state_reg)
            MD_IDLE:
            begin
                if (start)
                begin
                    a_next     = a;
                    b_next     = b;
                    c_next     = c;
                    prod_next  = '0;
                    step_next  = '0;
                    state_next = MD_MUL;
                end
            end
            MD_MUL:
            begin
                case (step_reg[1:0])
                    2'd0:    pp_next = {32'd0, a_reg[31:0]} * {32'd0, b_reg[31:0]};
                    2'd1:    pp_next = {32'd0, a_reg[31:0]} * {32'd0, b_reg[63:32]};
                    2'd2:    pp_next = {32'd0, a_reg[63:32]} * {32'd0, b_reg[31:0]};
                    default: pp_next = {32'd0, a_reg[63:32]} * {32'd0, b_reg[63:32]};
                endcase
                // partial product of the previous step lands here
                if (step_reg != 7'd0)
                begin
                    prod_next = prod_reg + pp_sh;
                end
                if (step_reg == 7'd4)
                begin
                    step_next  = '0;
                    rem_next   = '0;
                    quo_next   = '0;
                    state_next = MD_DIV;
                end
                else
                begin
                    step_next = step_reg + 7'd1;
                end
            end
            MD_DIV:
            begin
                prod_next = prod_reg << 1;
                if (rem2 >= {1'b0, c_reg})
                begin
                    rem_next = diff[63:0];
                    quo_next = {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rem2[63:0];
                    quo_next = {quo_reg[62:0], 1'b0};
                end
                if (step_reg == 7'd127)
                begin
                    done_next  = 1'b1;
                    state_next = MD_IDLE;
                end
                else
                begin
                    step_next = step_reg + 7'd1;
                end
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    assign res.done    = done_reg;
    assign res.quot    = quo_reg;
    assign res.inexact = (rem_reg != 64'd0);

endmodule

@@ rtl/core/tics_sqrt.sv @@
// Ceiling square root of a 64-bit value: 32 bit-pair steps, then one
// squaring to round up.
module tics_sqrt
    import tics_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] v,
    output sq_res_t     res
);

    sq_state_t   state_reg, state_next;
    logic [63:0] v_reg, v_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic [4:0]  step_reg, step_next;
    logic [63:0] sq_reg, sq_next;
    logic [32:0] root_reg, root_next;
    logic        done_reg, done_next;

    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SQ_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        x_reg    <= x_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        step_reg <= step_next;
        sq_reg   <= sq_next;
        root_reg <= root_next;
    end

    always_comb
    begin
        state_next = state_reg;
        v_next     = v_reg;
        x_next     = x_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        step_next  = step_reg;
        sq_next    = sq_reg;
        root_next  = root_reg;
        done_next  = 1'b0;
        case (state_reg)
            SQ_IDLE:
            begin
                if (start)
                begin
                    v_next     = v;
                    x_next     = v;
                    res_next   = '0;
                    bit_next   = 64'h4000_0000_0000_0000;
                    step_next  = '0;
                    state_next = SQ_RUN;
                end
            end
            SQ_RUN:
            begin
                if (x_reg >= trial)
                begin
                    x_next   = x_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (step_reg == 5'd31)
                begin
                    state_next = SQ_SQR;
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end
            SQ_SQR:
            begin
                sq_next    = {32'd0, res_reg[31:0]} * {32'd0, res_reg[31:0]};
                state_next = SQ_FIX;
            end
            SQ_FIX:
            begin
                if (sq_reg < v_reg)
                begin
                    root_next = {1'b0, res_reg[31:0]} + 33'd1;
                end
                else
                begin
                    root_next = {1'b0, res_reg[31:0]};
                end
                done_next  = 1'b1;
                state_next = SQ_IDLE;
            end
            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    assign res.done = done_reg;
    assign res.root = root_reg;

endmodule

@@ rtl/core/tabulated_inverse_cdf_sampler.sv @@
// Piecewise-linear inverse-CDF sampler. Issue an item with start while busy
// is low; its single result appears on value/status for exactly one cycle
// with done high, and cannot be held off, so capture it then. A plain load
// point answers in the next cycle. The final load point pads and checks the
// table and builds the cumulative sum slot by slot. A density query runs a
// binary search and then one pass of the multiply-divide unit. A sample
// takes three binary searches (up to 12 steps each) plus up to two passes
// of the bit-serial multiply-divide unit and a square root; that unit
// produces one quotient bit per cycle. Empty queries and errors found at
// start answer in the next cycle. All table words live in two
// single-port-read memories.
module tabulated_inverse_cdf_sampler
    import tics_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         opcode,
    input  logic [31:0]        energy,
    input  logic [31:0]        upper_energy,
    input  logic signed [31:0] density,
    input  logic [31:0]        uniform_fraction,
    input  logic               last_point,
    output logic               done,
    output logic [31:0]        value,
    output logic [2:0]         status
);

    // {energy, density} per slot, and the doubled cumulative area
    logic [63:0] ed_mem [TABLE_DEPTH];
    logic [63:0] c_mem [TABLE_DEPTH];
    logic [63:0] ed_rdata_reg;
    logic [63:0] c_rdata_reg;

    logic             ed_we;
    logic [IDX_W-1:0] ed_waddr;
    logic [63:0]      ed_wdata;
    logic             c_we;
    logic [IDX_W-1:0] c_waddr;
    logic [63:0]      c_wdata;
    logic [IDX_W-1:0] rd_addr;

    fsm_t             state_reg, state_next;
    search_mode_t     mode_reg, mode_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             valid_reg, valid_next;
    logic [31:0]      e_reg, e_next;
    logic [31:0]      emax_reg, emax_next;
    logic [31:0]      u_reg, u_next;
    logic [31:0]      efirst_reg, efirst_next;
    logic [31:0]      elast_reg, elast_next;
    logic [31:0]      dlast_reg, dlast_next;
    logic [IDX_W-1:0] lo_reg, lo_next;
    logic [IDX_W-1:0] hi_reg, hi_next;
    logic [IDX_W-1:0] mid_reg, mid_next;
    logic [IDX_W-1:0] rlo_reg, rlo_next;
    logic [IDX_W-1:0] rhi_reg, rhi_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [31:0]      prev_e_reg, prev_e_next;
    logic [31:0]      prev_d_reg, prev_d_next;
    logic [63:0]      acc_reg, acc_next;
    logic [63:0]      prod_reg, prod_next;
    logic [63:0]      clo_reg, clo_next;
    logic [63:0]      dd_reg, dd_next;
    logic [63:0]      r_reg, r_next;
    logic [63:0]      pa_reg, pa_next;
    logic [63:0]      pb_reg, pb_next;
    logic [31:0]      ea_reg, ea_next;
    logic [31:0]      eb_reg, eb_next;
    logic [31:0]      fa_reg, fa_next;
    logic [31:0]      fb_reg, fb_next;
    logic [31:0]      dx_reg, dx_next;
    logic [63:0]      df_reg, df_next;
    logic [63:0]      rem_reg, rem_next;
    logic [63:0]      y_reg, y_next;
    logic             done_reg, done_next;
    logic [31:0]      value_reg, value_next;
    stat_t            status_reg, status_next;

    logic             fin_en;
    logic [31:0]      fin_val;
    stat_t            fin_stat;

    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] load_base;
    logic [IDX_W:0]   mid_sum;
    logic [31:0]      rd_e;
    logic [31:0]      rd_d;
    logic [63:0]      rd_c;
    logic [32:0]      dsum;
    logic [63:0]      acc_sum;
    logic [63:0]      den_w;
    logic             go_up;

    logic             md_start;
    logic [63:0]      md_a;
    logic [63:0]      md_b;
    logic [63:0]      md_c;
    md_res_t          md_res;
    logic             sq_start;
    logic [63:0]      sq_v;
    sq_res_t          sq_res;

    tics_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_start),
        .a     (md_a),
        .b     (md_b),
        .c     (md_c),
        .res   (md_res)
    );

    tics_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .v     (sq_v),
        .res   (sq_res)
    );

    assign last_idx  = cnt_reg + IDX_W'(1);
    assign load_base = valid_reg ? '0 : cnt_reg;
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign rd_e      = ed_rdata_reg[63:32];
    assign rd_d      = ed_rdata_reg[31:0];
    assign rd_c      = c_rdata_reg;
    assign dsum      = {1'b0, rd_d} + {1'b0, prev_d_reg};
    assign acc_sum   = acc_reg + prod_reg;
    assign den_w     = {31'd0, sq_res.root} + {32'd0, fa_reg};

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign value  = value_reg;
    assign status = status_reg;

    always_ff @(posedge clk)
    begin
        if (ed_we)
        begin
            ed_mem[ed_waddr] <= ed_wdata;
        end
        ed_rdata_reg <= ed_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            c_mem[c_waddr] <= c_wdata;
        end
        c_rdata_reg <= c_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= M_EMIN;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg      <= e_next;
        emax_reg   <= emax_next;
        u_reg      <= u_next;
        efirst_reg <= efirst_next;
        elast_reg  <= elast_next;
        dlast_reg  <= dlast_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        rlo_reg    <= rlo_next;
        rhi_reg    <= rhi_next;
        k_reg      <= k_next;
        prev_e_reg <= prev_e_next;
        prev_d_reg <= prev_d_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        clo_reg    <= clo_next;
        dd_reg     <= dd_next;
        r_reg      <= r_next;
        pa_reg     <= pa_next;
        pb_reg     <= pb_next;
        ea_reg     <= ea_next;
        eb_reg     <= eb_next;
        fa_reg     <= fa_next;
        fb_reg     <= fb_next;
        dx_reg     <= dx_next;
        df_reg     <= df_next;
        rem_reg    <= rem_next;
        y_reg      <= y_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        case (mode_reg)
            M_EMIN:  go_up = (rd_e < e_reg);
            M_EMAX:  go_up = (rd_e < emax_reg);
            M_CUM:   go_up = (rd_c < r_reg);
            default: go_up = !(e_reg < rd_e);
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        cnt_next    = cnt_reg;
        valid_next  = valid_reg;
        e_next      = e_reg;
        emax_next   = emax_reg;
        u_next      = u_reg;
        efirst_next = efirst_reg;
        elast_next  = elast_reg;
        dlast_next  = dlast_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        rlo_next    = rlo_reg;
        rhi_next    = rhi_reg;
        k_next      = k_reg;
        prev_e_next = prev_e_reg;
        prev_d_next = prev_d_reg;
        acc_next    = acc_reg;
        prod_next   = prod_reg;
        clo_next    = clo_reg;
        dd_next     = dd_reg;
        r_next      = r_reg;
        pa_next     = pa_reg;
        pb_next     = pb_reg;
        ea_next     = ea_reg;
        eb_next     = eb_reg;
        fa_next     = fa_reg;
        fb_next     = fb_reg;
        dx_next     = dx_reg;
        df_next     = df_reg;
        rem_next    = rem_reg;
        y_next      = y_reg;
        value_next  = value_reg;
        status_next = status_reg;
        done_next   = 1'b0;

        fin_en   = 1'b0;
        fin_val  = '0;
        fin_stat = STAT_OK;

        ed_we    = 1'b0;
        ed_waddr = '0;
        ed_wdata = '0;
        c_we     = 1'b0;
        c_waddr  = '0;
        c_wdata  = '0;
        rd_addr  = '0;
        md_start = 1'b0;
        md_a     = '0;
        md_b     = '0;
        md_c     = '0;
        sq_start = 1'b0;
        sq_v     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    e_next    = energy;
                    emax_next = upper_energy;
                    u_next    = uniform_fraction;
                    case (opcode)
                        OP_LOAD:
                        begin
                            valid_next = 1'b0;
                            if (load_base >= IDX_W'(TABLE_DEPTH - 2))
                            begin
                                cnt_next = '0;
                                fin_en   = 1'b1;
                                fin_stat = STAT_FULL;
                            end
                            else
                            begin
                                cnt_next = load_base + IDX_W'(1);
                                ed_we    = 1'b1;
                                ed_waddr = load_base + IDX_W'(1);
                                ed_wdata = {energy, $unsigned(density)};
                                if (last_point)
                                begin
                                    elast_next = energy;
                                    dlast_next = $unsigned(density);
                                    state_next = S_BLD_PAD;
                                end
                                else
                                begin
                                    fin_en = 1'b1;
                                end
                            end
                        end
                        OP_SAMPLE:
                        begin
                            if (!valid_reg)
                            begin
                                fin_en   = 1'b1;
                                fin_stat = STAT_FULL;
                            end
                            else if (energy > upper_energy || upper_energy < efirst_reg)
                            begin
                                fin_en   = 1'b1;
                                fin_stat = STAT_EMPTY;
                            end
                            else
                            begin
                                lo_next    = '0;
                                hi_next    = last_idx;
                                mode_next  = M_EMIN;
                                state_next = S_SRCH_RD;
                            end
                        end
                        OP_INTERP:
                        begin
                            if (!valid_reg)
                            begin
                                fin_en   = 1'b1;
                                fin_stat = STAT_FULL;
                            end
                            else if (energy < efirst_reg || energy > elast_reg)
                            begin
                                fin_en = 1'b1;
                            end
                            else if (energy == elast_reg)
                            begin
                                fin_en  = 1'b1;
                                fin_val = dlast_reg;
                            end
                            else
                            begin
                                lo_next    = '0;
                                hi_next    = last_idx;
                                mode_next  = M_INT;
                                state_next = S_SRCH_RD;
                            end
                        end
                        default:
                        begin
                            fin_en = 1'b1;
                        end
                    endcase
                end
            end

            // high pad, and fetch slot 1 for the low pad
            S_BLD_PAD:
            begin
                ed_we      = 1'b1;
                ed_waddr   = last_idx;
                ed_wdata   = {elast_reg, 32'd0};
                rd_addr    = IDX_W'(1);
                state_next = S_BLD_FIRST;
            end
            S_BLD_FIRST:
            begin
                efirst_next = rd_e;
                ed_we       = 1'b1;
                ed_waddr    = '0;
                ed_wdata    = {rd_e, 32'd0};
                k_next      = '0;
                acc_next    = '0;
                state_next  = S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                rd_addr    = k_reg;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                prev_e_next = rd_e;
                prev_d_next = rd_d;
                state_next  = S_SCAN_ACC;
                if (k_reg == '0)
                begin
                    prod_next = '0;
                end
                else
                begin
                    prod_next = {32'd0, rd_e - prev_e_reg} * {31'd0, dsum};
                    if (prev_e_reg > rd_e)
                    begin
                        cnt_next = '0;
                        fin_en   = 1'b1;
                        fin_stat = STAT_ORDER;
                    end
                    else if (prev_d_reg[31])
                    begin
                        cnt_next = '0;
                        fin_en   = 1'b1;
                        fin_stat = STAT_NEG;
                    end
                end
            end
            S_SCAN_ACC:
            begin
                acc_next = acc_sum;
                c_we     = 1'b1;
                c_waddr  = k_reg;
                c_wdata  = acc_sum;
                if (k_reg == last_idx)
                begin
                    fin_en = 1'b1;
                    if (acc_sum == 64'd0)
                    begin
                        cnt_next = '0;
                        fin_stat = STAT_NEG;
                    end
                    else
                    begin
                        valid_next = 1'b1;
                    end
                end
                else
                begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = S_SCAN_RD;
                end
            end

            S_SRCH_RD:
            begin
                if (hi_reg - lo_reg > IDX_W'(1))
                begin
                    mid_next   = mid_sum[IDX_W:1];
                    rd_addr    = mid_sum[IDX_W:1];
                    state_next = S_SRCH_CMP;
                end
                else
                begin
                    case (mode_reg)
                        M_EMIN:
                        begin
                            rlo_next  = (lo_reg == '0) ? '0 : lo_reg - IDX_W'(1);
                            lo_next   = '0;
                            hi_next   = last_idx;
                            mode_next = M_EMAX;
                        end
                        M_EMAX:
                        begin
                            rhi_next   = hi_reg;
                            state_next = S_RNG_RD;
                        end
                        M_CUM:
                        begin
                            state_next = S_BIN_RDA;
                        end
                        default:
                        begin
                            state_next = S_INT_RDA;
                        end
                    endcase
                end
            end
            S_SRCH_CMP:
            begin
                if (go_up)
                begin
                    lo_next = mid_reg;
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_SRCH_RD;
            end

            S_RNG_RD:
            begin
                rd_addr    = rlo_reg;
                state_next = S_RNG_LO;
            end
            S_RNG_LO:
            begin
                clo_next   = rd_c;
                rd_addr    = rhi_reg;
                state_next = S_RNG_HI;
            end
            S_RNG_HI:
            begin
                dd_next    = (rd_c >= clo_reg) ? rd_c - clo_reg : 64'd0;
                state_next = S_RNG_MUL;
            end
            S_RNG_MUL:
            begin
                pa_next    = {32'd0, dd_reg[63:32]} * {32'd0, u_reg};
                pb_next    = {32'd0, dd_reg[31:0]} * {32'd0, u_reg};
                state_next = S_RNG_SUM;
            end
            S_RNG_SUM:
            begin
                r_next     = clo_reg + pa_reg + {32'd0, pb_reg[63:32]};
                lo_next    = '0;
                hi_next    = last_idx;
                mode_next  = M_CUM;
                state_next = S_SRCH_RD;
            end

            S_BIN_RDA:
            begin
                rd_addr    = lo_reg;
                state_next = S_BIN_A;
            end
            S_BIN_A:
            begin
                clo_next   = rd_c;
                ea_next    = rd_e;
                fa_next    = rd_d;
                rd_addr    = hi_reg;
                state_next = S_BIN_B;
            end
            S_BIN_B:
            begin
                eb_next    = rd_e;
                fb_next    = rd_d;
                dx_next    = rd_e - ea_reg;
                df_next    = rd_c - clo_reg;
                rem_next   = (r_reg >= clo_reg) ? r_reg - clo_reg : 64'd0;
                state_next = S_BIN_SQ;
            end
            S_BIN_SQ:
            begin
                if (df_reg == 64'd0)
                begin
                    // zero-area bin: lower edge
                    y_next     = '0;
                    state_next = S_FIN_A;
                end
                else
                begin
                    pa_next    = {32'd0, fa_reg} * {32'd0, fa_reg};
                    pb_next    = {32'd0, fb_reg} * {32'd0, fb_reg};
                    state_next = S_BIN_GO;
                end
            end
            S_BIN_GO:
            begin
                md_start = 1'b1;
                md_c     = df_reg;
                if (fa_reg == fb_reg)
                begin
                    md_a       = rem_reg;
                    md_b       = {32'd0, dx_reg};
                    state_next = S_LIN_WAIT;
                end
                else
                begin
                    md_a       = (fb_reg > fa_reg) ? pb_reg - pa_reg : pa_reg - pb_reg;
                    md_b       = rem_reg;
                    state_next = S_QMD_WAIT;
                end
            end
            S_LIN_WAIT:
            begin
                if (md_res.done)
                begin
                    y_next     = md_res.quot;
                    state_next = S_FIN_A;
                end
            end
            S_QMD_WAIT:
            begin
                if (md_res.done)
                begin
                    sq_start = 1'b1;
                    // round the quotient toward the larger root argument
                    if (fb_reg > fa_reg)
                    begin
                        sq_v = pa_reg + md_res.quot + {63'd0, md_res.inexact};
                    end
                    else
                    begin
                        sq_v = pa_reg - md_res.quot;
                    end
                    state_next = S_SQRT_WAIT;
                end
            end
            S_SQRT_WAIT:
            begin
                if (sq_res.done)
                begin
                    if (den_w == 64'd0)
                    begin
                        y_next     = '0;
                        state_next = S_FIN_A;
                    end
                    else
                    begin
                        md_start   = 1'b1;
                        md_a       = rem_reg;
                        md_b       = 64'd1;
                        md_c       = den_w;
                        state_next = S_DIV_WAIT;
                    end
                end
            end
            S_DIV_WAIT:
            begin
                if (md_res.done)
                begin
                    y_next     = md_res.quot;
                    state_next = S_FIN_A;
                end
            end
            S_FIN_A:
            begin
                y_next = ((y_reg > {32'd0, dx_reg}) ? {32'd0, dx_reg} : y_reg)
                         + {32'd0, ea_reg};
                state_next = S_FIN_B;
            end
            S_FIN_B:
            begin
                fin_en  = 1'b1;
                fin_val = (y_reg > {32'd0, emax_reg}) ? emax_reg : y_reg[31:0];
            end

            S_INT_RDA:
            begin
                rd_addr    = lo_reg;
                state_next = S_INT_A;
            end
            S_INT_A:
            begin
                ea_next    = rd_e;
                fa_next    = rd_d;
                rd_addr    = lo_reg + IDX_W'(1);
                state_next = S_INT_B;
            end
            S_INT_B:
            begin
                eb_next    = rd_e;
                fb_next    = rd_d;
                dx_next    = rd_e - ea_reg;
                state_next = S_INT_MUL;
            end
            S_INT_MUL:
            begin
                pa_next    = {32'd0, fa_reg} * {32'd0, eb_reg - e_reg};
                pb_next    = {32'd0, fb_reg} * {32'd0, e_reg - ea_reg};
                state_next = S_INT_GO;
            end
            S_INT_GO:
            begin
                md_start   = 1'b1;
                md_a       = pa_reg + pb_reg;
                md_b       = 64'd1;
                md_c       = {32'd0, dx_reg};
                state_next = S_INT_WAIT;
            end
            S_INT_WAIT:
            begin
                if (md_res.done)
                begin
                    fin_en  = 1'b1;
                    fin_val = md_res.quot[31:0];
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin_en)
        begin
            done_next   = 1'b1;
            value_next  = fin_val;
            status_next = fin_stat;
            state_next  = S_IDLE;
        end
    end

    a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted item neither in progress nor answered");

    a_valid_has_points: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (cnt_reg != '0))
        else $error("valid table with no points");

    a_error_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg != STAT_OK) |-> (value_reg == '0))
        else $error("error result with nonzero value");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN_ACC) |-> (k_reg <= last_idx))
        else $error("build scan ran past the high pad");

endmodule

@@ tb/sv/tabulated_inverse_cdf_sampler_tb.sv @@
module tabulated_inverse_cdf_sampler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tics_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         STALL_LIMIT = 60000;
    localparam int         DRAIN_CYCLES = 400;
    localparam int         RANDOM_ITEMS = 1800;

    typedef struct {
        logic [1:0]  opcode;
        logic [31:0] energy;
        logic [31:0] upper_energy;
        logic [31:0] density;
        logic [31:0] uniform_fraction;
        logic        last_point;
    } item_t;

    typedef struct {
        logic [31:0] value;
        logic [2:0]  status;
    } answer_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         opcode;
    logic [31:0]        energy;
    logic [31:0]        upper_energy;
    logic signed [31:0] density;
    logic [31:0]        uniform_fraction;
    logic               last_point;
    logic               done;
    logic [31:0]        value;
    logic [2:0]         status;

    tabulated_inverse_cdf_sampler u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .opcode           (opcode),
        .energy           (energy),
        .upper_energy     (upper_energy),
        .density          (density),
        .uniform_fraction (uniform_fraction),
        .last_point       (last_point),
        .done             (done),
        .value            (value),
        .status           (status)
    );

    // model of the table contents
    logic [31:0] tbl_energy [TABLE_DEPTH];
    logic [31:0] tbl_density [TABLE_DEPTH];
    logic [63:0] tbl_cum [TABLE_DEPTH];
    int unsigned tbl_count;
    bit          tbl_valid;

    answer_t     pending_answers[$];
    int          error_count;
    int          idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [63:0] mul_div_floor(input logic [63:0] a, input logic [63:0] b,
                                                  input logic [63:0] c, output bit inexact);
        logic [127:0] prod;
        logic [127:0] quot;
        prod = {64'd0, a} * {64'd0, b};
        quot = prod / {64'd0, c};
        inexact = (prod % {64'd0, c}) != 0;
        return quot[63:0];
    endfunction

    function automatic logic [63:0] root_ceil(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bv;
        x = v;
        res = 0;
        bv = 64'h4000_0000_0000_0000;
        while (bv > x)
            bv = bv >> 2;
        while (bv != 0)
        begin
            if (x >= res + bv)
            begin
                x = x - (res + bv);
                res = (res >> 1) + bv;
            end
            else
                res = res >> 1;
            bv = bv >> 2;
        end
        if (res * res < v)
            res = res + 1;
        return res;
    endfunction

    function automatic stat_t close_table();
        int unsigned top;
        logic [63:0] h;
        logic [63:0] s;
        top = tbl_count + 1;
        tbl_energy[0] = tbl_energy[1];
        tbl_density[0] = 0;
        tbl_energy[top] = tbl_energy[tbl_count];
        tbl_density[top] = 0;
        for (int unsigned i = 0; i < top; i++)
        begin
            if (tbl_energy[i] > tbl_energy[i+1])
                return STAT_ORDER;
            if (tbl_density[i][31])
                return STAT_NEG;
        end
        tbl_cum[0] = 0;
        for (int unsigned i = 1; i <= top; i++)
        begin
            h = {32'd0, tbl_energy[i] - tbl_energy[i-1]};
            s = {32'd0, tbl_density[i]} + {32'd0, tbl_density[i-1]};
            tbl_cum[i] = tbl_cum[i-1] + h * s;
        end
        return (tbl_cum[top] == 0) ? STAT_NEG : STAT_OK;
    endfunction

    function automatic logic [31:0] sample_energy(input logic [31:0] emin,
                                                  input logic [31:0] emax,
                                                  input logic [31:0] u);
        int unsigned top, i, j, k, lo, hi, a, b;
        logic [63:0] d, r, dx, df, rem, y, fa, fb, q, t, den, add;
        bit inexact;
        top = tbl_count + 1;
        i = 0;
        j = top;
        while (j - i > 1)
        begin
            k = (i + j) / 2;
            if (tbl_energy[k] < emin) i = k; else j = k;
        end
        lo = (i != 0) ? i - 1 : 0;
        i = 0;
        j = top;
        while (j - i > 1)
        begin
            k = (i + j) / 2;
            if (tbl_energy[k] < emax) i = k; else j = k;
        end
        hi = j;
        d = (tbl_cum[hi] >= tbl_cum[lo]) ? tbl_cum[hi] - tbl_cum[lo] : 0;
        r = tbl_cum[lo] + (d >> 32) * {32'd0, u} + (({32'd0, d[31:0]} * {32'd0, u}) >> 32);
        a = 0;
        b = top;
        while (b - a > 1)
        begin
            k = (a + b) / 2;
            if (tbl_cum[k] < r) a = k; else b = k;
        end
        dx = {32'd0, tbl_energy[b] - tbl_energy[a]};
        df = tbl_cum[b] - tbl_cum[a];
        rem = (r >= tbl_cum[a]) ? r - tbl_cum[a] : 0;
        if (df == 0)
            y = 0;
        else
        begin
            fa = {32'd0, tbl_density[a]};
            fb = {32'd0, tbl_density[b]};
            if (fa == fb)
                y = mul_div_floor(rem, dx, df, inexact);
            else
            begin
                if (fb > fa)
                begin
                    add = mul_div_floor(fb * fb - fa * fa, rem, df, inexact);
                    if (inexact) add = add + 1;
                    q = fa * fa + add;
                end
                else
                    q = fa * fa - mul_div_floor(fa * fa - fb * fb, rem, df, inexact);
                t = root_ceil(q);
                den = t + fa;
                y = (den != 0) ? rem / den : 0;
            end
        end
        if (y > dx)
            y = dx;
        y = y + {32'd0, tbl_energy[a]};
        if (y > {32'd0, emax})
            y = {32'd0, emax};
        return y[31:0];
    endfunction

    function automatic logic [31:0] density_at(input logic [31:0] e);
        int unsigned top, i, j, k;
        logic [63:0] w0, w1, acc;
        top = tbl_count + 1;
        if (e < tbl_energy[0] || e > tbl_energy[top])
            return 0;
        if (e == tbl_energy[top])
            return tbl_density[tbl_count];
        i = 0;
        j = top;
        while (j - i > 1)
        begin
            k = (i + j) / 2;
            if (e < tbl_energy[k]) j = k; else i = k;
        end
        w0 = {32'd0, tbl_energy[i+1] - e};
        w1 = {32'd0, e - tbl_energy[i]};
        acc = {32'd0, tbl_density[i]} * w0 + {32'd0, tbl_density[i+1]} * w1;
        acc = acc / {32'd0, tbl_energy[i+1] - tbl_energy[i]};
        return acc[31:0];
    endfunction

    function automatic answer_t predict_answer(input item_t it);
        answer_t ans;
        ans.value = 0;
        ans.status = STAT_OK;
        if (it.opcode == OP_LOAD)
        begin
            if (tbl_valid)
            begin
                tbl_valid = 0;
                tbl_count = 0;
            end
            if (tbl_count >= TABLE_DEPTH - 2)
            begin
                tbl_count = 0;
                ans.status = STAT_FULL;
            end
            else
            begin
                tbl_count++;
                tbl_energy[tbl_count] = it.energy;
                tbl_density[tbl_count] = it.density;
                if (it.last_point)
                begin
                    ans.status = close_table();
                    if (ans.status == STAT_OK) tbl_valid = 1;
                    else tbl_count = 0;
                end
            end
        end
        else if (it.opcode == OP_SAMPLE || it.opcode == OP_INTERP)
        begin
            if (!tbl_valid)
                ans.status = STAT_FULL;
            else if (it.opcode == OP_INTERP)
                ans.value = density_at(it.energy);
            else if (it.energy > it.upper_energy || it.upper_energy < tbl_energy[0])
                ans.status = STAT_EMPTY;
            else
                ans.value = sample_energy(it.energy, it.upper_energy, it.uniform_fraction);
        end
        return ans;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // called at a rising edge; returns at the edge the item is accepted, or later
    task automatic send_item(input item_t it, input bit no_gap = 0);
        int gap;
        start <= 1'b1;
        opcode <= it.opcode;
        energy <= it.energy;
        upper_energy <= it.upper_energy;
        density <= it.density;
        uniform_fraction <= it.uniform_fraction;
        last_point <= it.last_point;
        do
            @(posedge clk);
        while (busy);
        pending_answers.push_back(predict_answer(it));
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_op(input logic [1:0] op, input logic [31:0] e, input logic [31:0] emax,
                           input logic [31:0] d, input logic [31:0] u, input bit fin,
                           input bit no_gap = 0);
        item_t it;
        it.opcode = op;
        it.energy = e;
        it.upper_energy = emax;
        it.density = d;
        it.uniform_fraction = u;
        it.last_point = fin;
        send_item(it, no_gap);
    endtask

    task automatic load_point(input logic [31:0] e, input logic [31:0] d, input bit fin);
        send_op(OP_LOAD, e, $urandom, d, $urandom, fin);
    endtask

    task automatic test_no_table();
        send_op(OP_SAMPLE, 32'h0001_0000, 32'h0004_0000, $urandom, $urandom, 0);
        send_op(OP_INTERP, 32'h0001_0000, $urandom, $urandom, $urandom, 1);
    endtask

    task automatic test_directed();
        // flat bin, falling bin, zero-width step, falling to zero
        load_point(32'h0001_0000, 32'd100, 0);
        load_point(32'h0002_0000, 32'd100, 0);
        load_point(32'h0003_0000, 32'd0, 0);
        load_point(32'h0003_0000, 32'd50, 0);
        load_point(32'h0004_0000, 32'd0, 1);
        send_op(OP_SAMPLE, 32'h0001_0000, 32'h0004_0000, 0, 32'h0000_0000, 0);
        send_op(OP_SAMPLE, 32'h0001_0000, 32'h0004_0000, 0, 32'hFFFF_FFFF, 0);
        send_op(OP_SAMPLE, 32'h0000_0000, 32'hFFFF_FFFF, 0, 32'h8000_0000, 0);
        send_op(OP_SAMPLE, 32'h0002_8000, 32'h0002_8000, 0, $urandom, 0);
        send_op(OP_SAMPLE, 32'h0003_0000, 32'h0001_0000, 0, $urandom, 0);
        send_op(OP_SAMPLE, 32'h0000_0000, 32'h0000_8000, 0, $urandom, 0);
        send_op(OP_INTERP, 32'h0000_8000, 0, 0, 0, 0);
        send_op(OP_INTERP, 32'h0001_8000, 0, 0, 0, 0);
        send_op(OP_INTERP, 32'h0003_0000, 0, 0, 0, 0);
        send_op(OP_INTERP, 32'h0004_0000, 0, 0, 0, 0);
        send_op(OP_INTERP, 32'hFFFF_FFFF, 0, 0, 0, 0);
        send_op(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, 1);
        // widest table
        load_point(32'h0000_0000, 32'h7FFF_FFFF, 0);
        load_point(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1);
        send_op(OP_SAMPLE, 32'h0000_0000, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0);
        send_op(OP_INTERP, 32'h8000_0000, 0, 0, 0, 0);
        // build failures: descending, negative, zero area
        load_point(32'h0005_0000, 32'd1, 0);
        load_point(32'h0004_0000, 32'd1, 1);
        load_point(32'h0005_0000, 32'h8000_0000, 1);
        load_point(32'h0005_0000, 32'd9, 1);
        send_op(OP_INTERP, 32'h0005_0000, 0, 0, 0, 0);
        // a load after a valid table drops it
        load_point(32'h0001_0000, 32'd4, 1);
        load_point(32'h0001_0000, 32'd4, 0);
        load_point(32'h0002_0000, 32'd4, 1);
        load_point(32'h0003_0000, 32'd4, 0);
        send_op(OP_SAMPLE, 32'h0001_0000, 32'h0002_0000, 0, $urandom, 0);
    endtask

    function automatic logic [31:0] pick_energy(input logic [31:0] lo, input logic [31:0] hi);
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return $urandom_range(hi, lo);
        if (r == 6) return lo;
        if (r == 7) return hi;
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_density(input int mode, input logic [31:0] prev);
        case (mode)
            0: return $urandom_range(0, 3) == 0 ? 32'd0 : $urandom_range(1, 255);
            1: return $urandom_range(0, 2) == 0 ? prev : $urandom_range(0, 65535);
            default: return $urandom & 32'h7FFF_FFFF;
        endcase
    endfunction

    task automatic test_random();
        int sent;
        int n, mode, qn;
        bit broken;
        logic [31:0] es[$];
        logic [31:0] ds[$];
        logic [31:0] base, a, b, tmp;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 24);
            broken = $urandom_range(0, 9) == 0;
            mode = $urandom_range(0, 2);
            es.delete();
            ds.delete();
            base = ($urandom_range(0, 1) == 0) ? ($urandom & 32'hFFE0_0000) : 0;
            for (int i = 0; i < n; i++)
            begin
                if (i > 0 && $urandom_range(0, 7) == 0)
                    es.push_back(es[i-1]);
                else if (mode == 2)
                    es.push_back($urandom);
                else
                    es.push_back(base + $urandom_range(0, 32'h001F_FFFF));
                ds.push_back(pick_density(mode, i > 0 ? ds[i-1] : 32'd0));
            end
            es.sort();
            if (broken)
            begin
                if ($urandom_range(0, 1) == 0)
                    ds[$urandom_range(0, n - 1)] = $urandom | 32'h8000_0000;
                else if (n > 1)
                begin
                    tmp = es[0];
                    es[0] = es[n-1];
                    es[n-1] = tmp;
                end
            end
            for (int i = 0; i < n; i++)
                load_point(es[i], ds[i], i == n - 1);
            sent += n;
            qn = $urandom_range(5, 30);
            for (int i = 0; i < qn; i++)
            begin
                case ($urandom_range(0, 19))
                    0: send_op(OP_UNUSED, $urandom, $urandom, $urandom, $urandom,
                               $urandom_range(0, 1));
                    1, 2, 3, 4, 5, 6:
                        send_op(OP_INTERP, pick_energy(es[0], es[n-1]), $urandom, $urandom,
                                $urandom, $urandom_range(0, 1));
                    default:
                    begin
                        a = pick_energy(es[0], es[n-1]);
                        b = pick_energy(es[0], es[n-1]);
                        if (a > b && $urandom_range(0, 9) != 0)
                        begin
                            tmp = a;
                            a = b;
                            b = tmp;
                        end
                        send_op(OP_SAMPLE, a, b, $urandom, $urandom, $urandom_range(0, 1));
                    end
                endcase
            end
            sent += qn;
        end
    endtask

    always @(posedge clk)
    begin
        answer_t exp_ans;
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("unexpected result value=%h status=%0d", value, status);
                error_count++;
            end
            else
            begin
                exp_ans = pending_answers.pop_front();
                if (value !== exp_ans.value)
                begin
                    $error("value: expected %h actual %h", exp_ans.value, value);
                    error_count++;
                end
                if (status !== exp_ans.status)
                begin
                    $error("status: expected %0d actual %0d", exp_ans.status, status);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake and no result
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tabulated_inverse_cdf_sampler test failed");
                $finish;
            end
        end
    end

    initial
    begin
        error_count = 0;
        idle_cycles = 0;
        tbl_count = 0;
        tbl_valid = 0;
        rst_n = 1'b0;
        start = 1'b0;
        opcode = OP_LOAD;
        energy = 0;
        upper_energy = 0;
        density = 0;
        uniform_fraction = 0;
        last_point = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_no_table();
        test_directed();
        test_random();
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_answers.size() == 0)
            $display("tabulated_inverse_cdf_sampler test passed");
        else
            $display("tabulated_inverse_cdf_sampler test failed");
        $finish;
    end

endmodule
